/* rtl/etf_pkg.sv */
// ----------------------------------------------------------------------------
// etf_pkg
// Shared types and constants for the escape-time fractal pixel unit.
// ----------------------------------------------------------------------------
package etf_pkg;

    // default number formats
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 28;
    localparam int INDEX_BITS_DEF = 12;

    // iteration count width
    localparam int ITER_BITS = 8;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_RE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_IM = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_RE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_IM   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER  = 3'd4;

    // reset values: step is about 0.005, given here at 28 fraction bits
    localparam int STEP_RESET_Q28 = 1342177;
    localparam int STEP_RESET_FB  = 28;
    localparam logic [ITER_BITS-1:0] MAX_ITER_RESET = 8'd200;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // take the pixel position
        logic c_mul;     // multiply steps by index+1
        logic c_load;    // form c, clear z and count
        logic z_mul;     // multiply z terms
        logic z_step;    // update z, advance count
        logic out_load;  // load the result register
    } t_etf_cmd;

    // datapath to controller status
    typedef struct packed {
        logic escaped;   // |z|^2 > 4
        logic at_limit;  // count reached max_iter
    } t_etf_sts;

endpackage

/* rtl/etf_ctrl.sv */
// ----------------------------------------------------------------------------
// etf_ctrl
// Sequencer for one pixel: setup of c, multiply/update loop and handoff of
// the result into the output register.
// ----------------------------------------------------------------------------
module etf_ctrl import etf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    output t_etf_cmd o_cmd,
    input  t_etf_sts i_sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMUL = 3'd1;
    localparam logic [2:0] S_CLOAD = 3'd2;
    localparam logic [2:0] S_ZMUL = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_HOLD = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    logic       done;

    // output register can take a result this cycle
    assign out_free = !r_out_valid || !i_stall;
    assign done     = i_sts.escaped || i_sts.at_limit;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CMUL;
                end
            end
            S_CMUL: begin
                o_cmd.c_mul = 1'b1;
                n_state     = S_CLOAD;
            end
            S_CLOAD: begin
                o_cmd.c_load = 1'b1;
                n_state      = S_ZMUL;
            end
            S_ZMUL: begin
                o_cmd.z_mul = 1'b1;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                if (!done) begin
                    o_cmd.z_step = 1'b1;
                    n_state      = S_ZMUL;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, drop when the item is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

/* rtl/etf_dp.sv */
// ----------------------------------------------------------------------------
// etf_dp
// Datapath: configuration registers, shared multipliers, saturating
// fixed-point update of z, escape test and the output register.
// ----------------------------------------------------------------------------
module etf_dp import etf_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]   i_cfg_data,
    input  logic [INDEX_BITS-1:0]   i_pixel_col,
    input  logic [INDEX_BITS-1:0]   i_pixel_row,
    input  t_etf_cmd                i_cmd,
    output t_etf_sts                o_sts,
    output logic [INDEX_BITS-1:0]   o_out_col,
    output logic [INDEX_BITS-1:0]   o_out_row,
    output logic [ITER_BITS-1:0]    o_iter_count
);

    // multiplier operand width covers coordinates and index+1
    localparam int MW = (COORD_BITS >= INDEX_BITS + 2) ? COORD_BITS : INDEX_BITS + 2;
    localparam int PW = 2 * MW;

    localparam logic signed [COORD_BITS-1:0] VMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] VMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [PW-1:0] VMAX_W = PW'(VMAX);
    localparam logic signed [PW-1:0] VMIN_W = PW'(VMIN);

    localparam logic [COORD_BITS-1:0] ONE_FX = COORD_BITS'(1) << FRAC_BITS;
    localparam logic [COORD_BITS-1:0] ORIGIN_RST = ~ONE_FX + COORD_BITS'(1);
    localparam logic [COORD_BITS-1:0] STEP_RST = COORD_BITS'((FRAC_BITS >= STEP_RESET_FB)
        ? (64'(STEP_RESET_Q28) << (FRAC_BITS - STEP_RESET_FB))
        : (64'(STEP_RESET_Q28) >> (STEP_RESET_FB - FRAC_BITS)));

    // escape threshold 4.0 in the exact square format
    localparam logic [PW:0] ESC_LIM = (PW+1)'(1) << (2 * FRAC_BITS + 2);

    // saturate a wide product to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] sat_w(input logic signed [PW-1:0] v);
        logic signed [COORD_BITS-1:0] res;
        if (v > VMAX_W) begin
            res = VMAX;
        end else if (v < VMIN_W) begin
            res = VMIN;
        end else begin
            res = $signed(v[COORD_BITS-1:0]);
        end
        return res;
    endfunction

    // saturating add
    function automatic logic signed [COORD_BITS-1:0] sadd(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] sum;
        logic signed [COORD_BITS-1:0] res;
        sum = (COORD_BITS+1)'(a) + (COORD_BITS+1)'(b);
        if (sum[COORD_BITS] != sum[COORD_BITS-1]) begin
            res = sum[COORD_BITS] ? VMIN : VMAX;
        end else begin
            res = $signed(sum[COORD_BITS-1:0]);
        end
        return res;
    endfunction

    logic signed [COORD_BITS-1:0] r_org_re, r_org_im, r_step_re, r_step_im;
    logic [ITER_BITS-1:0]         r_max_iter;
    logic [INDEX_BITS-1:0]        r_col, r_row;
    logic signed [COORD_BITS-1:0] r_c_re, r_c_im, r_z_re, r_z_im;
    logic [ITER_BITS-1:0]         r_k;
    logic signed [PW-1:0]         r_p_rr, r_p_ii, r_p_ri;
    logic [INDEX_BITS-1:0]        r_o_col, r_o_row;
    logic [ITER_BITS-1:0]         r_o_iter;

    logic signed [MW-1:0]         a0, b0, a1, b1, a2, b2;
    logic signed [COORD_BITS-1:0] rr, ii, ri, neg_ii;
    logic signed [COORD_BITS-1:0] n_c_re, n_c_im, n_z_re, n_z_im;
    logic [PW:0]                  mag_sum;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_re   <= ORIGIN_RST;
            r_org_im   <= ORIGIN_RST;
            r_step_re  <= STEP_RST;
            r_step_im  <= STEP_RST;
            r_max_iter <= MAX_ITER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_RE: r_org_re   <= i_cfg_data;
                CFG_ORIGIN_IM: r_org_im   <= i_cfg_data;
                CFG_STEP_RE:   r_step_re  <= i_cfg_data;
                CFG_STEP_IM:   r_step_im  <= i_cfg_data;
                CFG_MAX_ITER:  r_max_iter <= i_cfg_data[ITER_BITS-1:0];
                default: ;
            endcase
        end
    end

    // operand select: step times index+1 during setup, z terms otherwise
    always_comb begin
        if (i_cmd.c_mul) begin
            a0 = MW'(r_step_re);
            b0 = MW'({1'b0, r_col}) + MW'(1);
            a1 = MW'(r_step_im);
            b1 = MW'({1'b0, r_row}) + MW'(1);
            a2 = '0;
            b2 = '0;
        end else begin
            a0 = MW'(r_z_re);
            b0 = MW'(r_z_re);
            a1 = MW'(r_z_im);
            b1 = MW'(r_z_im);
            a2 = MW'(r_z_re);
            b2 = MW'(r_z_im);
        end
    end

    // register products
    always_ff @(posedge i_clk) begin
        if (i_cmd.c_mul || i_cmd.z_mul) begin
            r_p_rr <= PW'(a0) * PW'(b0);
            r_p_ii <= PW'(a1) * PW'(b1);
            r_p_ri <= PW'(a2) * PW'(b2);
        end
    end

    // floor to the fixed-point grid, saturate, then form the next z
    always_comb begin
        rr      = sat_w(r_p_rr >>> FRAC_BITS);
        ii      = sat_w(r_p_ii >>> FRAC_BITS);
        ri      = sat_w(r_p_ri >>> FRAC_BITS);
        neg_ii  = (ii == VMIN) ? VMAX : -ii;
        n_z_re  = sadd(sadd(rr, neg_ii), r_c_re);
        n_z_im  = sadd(sadd(ri, ri), r_c_im);
        n_c_re  = sadd(r_org_re, sat_w(r_p_rr));
        n_c_im  = sadd(r_org_im, sat_w(r_p_ii));
        mag_sum = {1'b0, r_p_rr} + {1'b0, r_p_ii};
    end

    // pixel, c, z and count
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col <= i_pixel_col;
            r_row <= i_pixel_row;
        end
        if (i_cmd.c_load) begin
            r_c_re <= n_c_re;
            r_c_im <= n_c_im;
            r_z_re <= '0;
            r_z_im <= '0;
            r_k    <= '0;
        end else if (i_cmd.z_step) begin
            r_z_re <= n_z_re;
            r_z_im <= n_z_im;
            r_k    <= r_k + ITER_BITS'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_col  <= r_col;
            r_o_row  <= r_row;
            r_o_iter <= r_k;
        end
    end

    assign o_sts.escaped  = (mag_sum > ESC_LIM);
    assign o_sts.at_limit = (r_k >= r_max_iter);
    assign o_out_col      = r_o_col;
    assign o_out_row      = r_o_row;
    assign o_iter_count   = r_o_iter;

endmodule

/* rtl/escape_time_fractal_pixel_unit.sv */
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_unit
// Mandelbrot escape-time count for one pixel in saturating fixed point.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------
//  pixel in | in        | i_valid / o_stall   | i_pixel_col, i_pixel_row
//  result   | out       | o_valid / i_stall   | o_out_col, o_out_row, o_iter_count
//  config   | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//
//  After acceptance, setup states S_CMUL and S_CLOAD form c; each iteration
//  then uses the shared multipliers (S_ZMUL) and saturating update (S_EVAL).
//  One item is in work at a time; the next is accepted while a result still
//  waits in the output register. A result that finds that register full holds
//  the unit until it drains. Synchronous reset restores the register defaults.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_unit import etf_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]   i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [INDEX_BITS-1:0]   i_pixel_col,
    input  logic [INDEX_BITS-1:0]   i_pixel_row,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [INDEX_BITS-1:0]   o_out_col,
    output logic [INDEX_BITS-1:0]   o_out_row,
    output logic [ITER_BITS-1:0]    o_iter_count
);

    t_etf_cmd cmd;
    t_etf_sts sts;

    // sequencer
    etf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // arithmetic and registers
    etf_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_iter_count (o_iter_count)
    );

endmodule
